// ----- rtl/llkm_pkg.sv -----
// shared types, constants and helpers for the literal list k-way merge block
package llkm_pkg;

    localparam int LIT_W      = 32;
    localparam int NUM_LANES  = 4;
    localparam int LANE_DEPTH = 16;
    localparam int LANE_W     = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
    localparam int CNT_W      = $clog2(LANE_DEPTH + 1);
    localparam int IDX_W      = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
    localparam int SEL_W      = 2;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // item kinds carried in the low tuser bit
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

    // one classified item waiting for the back end
    typedef struct packed {
        logic               is_run;
        logic [SEL_W-1:0]   lane;
        logic [LIT_W-1:0]   literal;
    } cmd_t;

    // magnitude as unsigned, so the most negative value maps to 2^31
    function automatic logic [LIT_W-1:0] lit_mag(input logic [LIT_W-1:0] v);
        lit_mag = v[LIT_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// ----- rtl/literal_list_kway_merge_resolve.sv -----
// top level of the literal list k-way merge with duplicate removal
//
//  channel  | dir | payload                                             | transfer
//  ---------+-----+-----------------------------------------------------+------------------
//  s_axis   | in  | tdata: literal; tuser: mode, lane[1:0]              | tvalid & tready
//  m_axis   | out | tdata: merged_literal; tlast: last;                 | tvalid & tready
//           |     | tuser: conflict, empty_res, overflow                |
//
//  loads stream at one per cycle while no run is in progress; a run leaves the queue,
//  then takes or drops the smallest head at each step and ends with a closing step, plus a
//  step to flush the held literal when a conflict ends it; results are registered
//  rst_n is asynchronous and active low; it empties the queue and all lanes
//  a stalled m_axis freezes the merge; the four entry queue keeps taking
//  s_axis transactions until it fills
//
module literal_list_kway_merge_resolve
    import llkm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [LIT_W-1:0] s_axis_tdata,   // literal
    input  logic [2:0]       s_axis_tuser,   // mode, lane[1:0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [LIT_W-1:0] m_axis_tdata,   // merged_literal
    output logic             m_axis_tlast,   // last
    output logic [2:0]       m_axis_tuser    // conflict, empty_res, overflow
);

    // command queue between the classifying front and the merge engine
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    llkm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop)
    );

    // lane stores, head pick, one-deep hold for the last flag, result register
    llkm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- rtl/llkm_front.sv -----
// front end: accepts and classifies input transactions into a short command queue
module llkm_front
    import llkm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [LIT_W-1:0] s_axis_tdata,   // literal
    input  logic [2:0]       s_axis_tuser,   // mode, lane[1:0]
    output logic             q_valid,
    output cmd_t             q_cmd,
    input  logic             q_pop
);

    cmd_t              fifo_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    cmd_t              in_cmd;

    always_comb
    begin
        in_cmd.is_run  = (s_axis_tuser[0] == MODE_RUN);
        in_cmd.lane    = s_axis_tuser[2:1];
        in_cmd.literal = s_axis_tdata;
    end

    assign s_axis_tready = (cnt_reg != QCNT_W'(QDEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (cnt_reg != '0);
    assign q_cmd         = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with empty count");

endmodule

// ----- rtl/llkm_back.sv -----
// back end: lane stores, head select merge engine and result register
module llkm_back
    import llkm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  cmd_t             q_cmd,
    output logic             q_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [LIT_W-1:0] m_axis_tdata,   // merged_literal
    output logic             m_axis_tlast,
    output logic [2:0]       m_axis_tuser    // conflict, empty_res, overflow
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg [NUM_LANES];
    logic [CNT_W-1:0] cnt_next [NUM_LANES];
    logic [CNT_W-1:0] rd_reg [NUM_LANES];
    logic [CNT_W-1:0] rd_next [NUM_LANES];
    logic             ovf_seen_reg, ovf_seen_next;
    logic             ovf_run_reg, ovf_run_next;
    logic             have_last_reg, have_last_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [LIT_W-1:0] last_lit_reg, last_lit_next;
    logic             out_valid_reg, out_valid_next;
    logic [LIT_W-1:0] out_lit_reg, out_lit_next;
    logic             out_last_reg, out_last_next;
    logic             out_cfl_reg, out_cfl_next;
    logic             out_emp_reg, out_emp_next;
    logic             out_ovf_reg, out_ovf_next;

    logic              wr_en;
    logic [LANE_W-1:0] wr_lane;
    logic              can_push;

    logic [LIT_W-1:0]  head_val [NUM_LANES];
    logic [LIT_W-1:0]  head_mag [NUM_LANES];
    logic              head_ok  [NUM_LANES];
    logic              found;
    logic [LANE_W-1:0] best_lane;
    logic [LIT_W-1:0]  best_val;
    logic [LIT_W-1:0]  best_mag;
    logic              is_conflict;
    logic              is_repeat;

    assign can_push = !out_valid_reg || m_axis_tready;
    assign wr_lane  = LANE_W'(q_cmd.lane);

    // one store per lane; the head is read ahead at the next read position,
    // a load into the slot being read is forwarded
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        logic [LIT_W-1:0] lane_mem [LANE_DEPTH];
        logic [LIT_W-1:0] head_reg;
        logic             lane_wr;
        logic             lane_fwd;

        assign lane_wr  = wr_en && (wr_lane == LANE_W'(g));
        assign lane_fwd = lane_wr && (cnt_reg[g][IDX_W-1:0] == rd_next[g][IDX_W-1:0]);

        always_ff @(posedge clk)
        begin
            if (lane_wr)
            begin
                lane_mem[cnt_reg[g][IDX_W-1:0]] <= q_cmd.literal;
            end
            head_reg <= lane_fwd ? q_cmd.literal : lane_mem[rd_next[g][IDX_W-1:0]];
        end

        assign head_val[g] = head_reg;
    end

    // lane heads and smallest-magnitude pick, lowest lane wins ties
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            head_ok[l]  = rd_reg[l] < cnt_reg[l];
            head_mag[l] = lit_mag(head_val[l]);
        end
        found     = 1'b0;
        best_lane = '0;
        best_val  = '0;
        best_mag  = '0;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            if (head_ok[l] && (!found || head_mag[l] < best_mag))
            begin
                found     = 1'b1;
                best_lane = LANE_W'(l);
                best_val  = head_val[l];
                best_mag  = head_mag[l];
            end
        end
        is_repeat   = have_last_reg && (best_val == last_lit_reg);
        is_conflict = have_last_reg && (best_val != last_lit_reg)
                      && ((best_val + last_lit_reg) == '0);
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_next         = rd_reg;
        ovf_seen_next   = ovf_seen_reg;
        ovf_run_next    = ovf_run_reg;
        have_last_next  = have_last_reg;
        pend_valid_next = pend_valid_reg;
        last_lit_next   = last_lit_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_lit_next    = out_lit_reg;
        out_last_next   = out_last_reg;
        out_cfl_next    = out_cfl_reg;
        out_emp_next    = out_emp_reg;
        out_ovf_next    = out_ovf_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.is_run)
                    begin
                        ovf_run_next    = ovf_seen_reg;
                        ovf_seen_next   = 1'b0;
                        have_last_next  = 1'b0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_RUN;
                    end
                    else if (int'(q_cmd.lane) < NUM_LANES)
                    begin
                        if (cnt_reg[wr_lane] == CNT_W'(LANE_DEPTH))
                        begin
                            ovf_seen_next = 1'b1;
                        end
                        else
                        begin
                            wr_en             = 1'b1;
                            cnt_next[wr_lane] = cnt_reg[wr_lane] + 1'b1;
                        end
                    end
                end
            end
            ST_RUN:
            begin
                if (can_push)
                begin
                    out_ovf_next = ovf_run_reg;
                    out_cfl_next = 1'b0;
                    out_emp_next = 1'b0;
                    if (!found || (is_conflict && !pend_valid_reg))
                    begin
                        // final transaction of the run
                        out_valid_next = 1'b1;
                        out_last_next  = 1'b1;
                        if (found)
                        begin
                            out_lit_next = best_val;
                            out_cfl_next = 1'b1;
                        end
                        else
                        begin
                            out_lit_next = pend_valid_reg ? last_lit_reg : '0;
                            out_emp_next = !pend_valid_reg;
                        end
                        for (int l = 0; l < NUM_LANES; l++)
                        begin
                            cnt_next[l] = '0;
                            rd_next[l]  = '0;
                        end
                        have_last_next  = 1'b0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                    else if (is_conflict)
                    begin
                        // flush the held literal, conflict follows next step
                        out_valid_next  = 1'b1;
                        out_last_next   = 1'b0;
                        out_lit_next    = last_lit_reg;
                        pend_valid_next = 1'b0;
                    end
                    else if (is_repeat)
                    begin
                        rd_next[best_lane] = rd_reg[best_lane] + 1'b1;
                    end
                    else
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b0;
                            out_lit_next   = last_lit_reg;
                        end
                        pend_valid_next    = 1'b1;
                        have_last_next     = 1'b1;
                        last_lit_next      = best_val;
                        rd_next[best_lane] = rd_reg[best_lane] + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                cnt_reg[l] <= '0;
                rd_reg[l]  <= '0;
            end
            ovf_seen_reg   <= 1'b0;
            ovf_run_reg    <= 1'b0;
            have_last_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            last_lit_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_lit_reg    <= '0;
            out_last_reg   <= 1'b0;
            out_cfl_reg    <= 1'b0;
            out_emp_reg    <= 1'b0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_reg         <= rd_next;
            ovf_seen_reg   <= ovf_seen_next;
            ovf_run_reg    <= ovf_run_next;
            have_last_reg  <= have_last_next;
            pend_valid_reg <= pend_valid_next;
            last_lit_reg   <= last_lit_next;
            out_valid_reg  <= out_valid_next;
            out_lit_reg    <= out_lit_next;
            out_last_reg   <= out_last_next;
            out_cfl_reg    <= out_cfl_next;
            out_emp_reg    <= out_emp_next;
            out_ovf_reg    <= out_ovf_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_lit_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_ovf_reg, out_emp_reg, out_cfl_reg};

    a_pend_has_last: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> have_last_reg)
        else $error("held literal without a last emitted value");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("literal still held after the run ended");

    a_special_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_emp_reg || out_cfl_reg)) |-> out_last_reg)
        else $error("empty or conflict transaction not marked last");

    a_lane0_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_reg[0] <= cnt_reg[0]) && (cnt_reg[0] <= CNT_W'(LANE_DEPTH)))
        else $error("lane 0 read position or count out of range");

endmodule
